FILE: src/scr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scr_pkg
// Types, widths and helpers shared by the sphere collision resolver.
// ----------------------------------------------------------------------------
package scr_pkg;

	// coordinates are signed fixed point; the fraction width never changes a bit
	localparam int COORD_BITS    = 32;
	localparam int RAD_BITS      = COORD_BITS - 1;
	localparam int SUM_BITS      = COORD_BITS;
	localparam int OFS_BITS      = COORD_BITS + 2;
	localparam int MAG_BITS      = COORD_BITS + 1;
	localparam int EXT_BITS      = COORD_BITS + 2;
	localparam int PROD_BITS     = MAG_BITS + RAD_BITS;
	localparam int SQ_BITS       = 2 * MAG_BITS;
	localparam int DIST_BITS     = SQ_BITS + 2;
	localparam int RADICAND_BITS = 2 * COORD_BITS;
	localparam int ROOT_BITS     = COORD_BITS;
	localparam int ROOT_REM_BITS = ROOT_BITS + 3;
	localparam int QUO_BITS      = COORD_BITS;
	localparam int DIV_REM_BITS  = QUO_BITS + 1;
	localparam int NUM_BITS      = 2 * COORD_BITS;
	localparam int AXES          = 3;

	typedef enum logic {
		OP_BOX    = 1'b0,
		OP_SPHERE = 1'b1
	} opcode_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [RAD_BITS-1:0] rad_t;

	typedef struct packed {
		opcode_t opcode;
		coord_t  player_x;
		coord_t  player_y;
		coord_t  player_z;
		rad_t    player_radius;
		coord_t  obstacle_x;
		coord_t  obstacle_y;
		coord_t  obstacle_z;
		rad_t    box_size_x;
		rad_t    box_size_y;
		rad_t    box_size_z;
		rad_t    obstacle_radius;
	} query_t;

	typedef struct packed {
		coord_t result_x;
		coord_t result_y;
		coord_t result_z;
	} result_t;

	// front end outcome: final position unless a push along the centre line is needed
	typedef struct packed {
		logic                               push;
		coord_t [AXES-1:0]                  base;
		coord_t [AXES-1:0]                  obst;
		logic   [AXES-1:0][MAG_BITS-1:0]    mag;
		logic   [AXES-1:0]                  neg;
		logic   [SUM_BITS-1:0]              sum;
	} front_t;

	function automatic coord_t sat_coord(input logic signed [EXT_BITS-1:0] v);
		logic [EXT_BITS-COORD_BITS:0] top;
		top = v[EXT_BITS-1:COORD_BITS-1];
		if (top == '0 || top == '1) begin
			return v[COORD_BITS-1:0];
		end else if (v[EXT_BITS-1]) begin
			return {1'b1, {(COORD_BITS-1){1'b0}}};
		end else begin
			return {1'b0, {(COORD_BITS-1){1'b1}}};
		end
	endfunction

endpackage
`default_nettype wire

FILE: src/scr_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scr_ifs
// Valid/ready channels for query words and result words.
// ----------------------------------------------------------------------------
interface scr_query_if;
	import scr_pkg::*;
	logic   valid;
	logic   ready;
	query_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface scr_result_if;
	import scr_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/sphere_collision_resolver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sphere_collision_resolver
// Resolves a player sphere against one box or sphere obstacle per word.
// ----------------------------------------------------------------------------
// One query word is taken every cycle that query.ready is high; each gives one
// result word after four front end stages, 32 square root stages, one multiply
// stage, 32 divider stages and the output register. The whole pipeline
// advances together; while the output register holds a word that is not
// taken, query.ready is low and nothing inside moves.
module sphere_collision_resolver (
	input  logic            clk,
	input  logic            arst_n,
	scr_query_if.sink       query,
	scr_result_if.source    result
);
	import scr_pkg::*;

	logic                     en;
	logic                     f_vld;
	front_t                   f_info;
	logic [RADICAND_BITS-1:0] f_rad;
	logic [ROOT_BITS-1:0]     root;

	logic                     sq_vld_s  [ROOT_BITS];
	front_t                   sq_info_s [ROOT_BITS];

	logic                     vld_smul;
	front_t                   info_smul;
	logic [NUM_BITS-1:0]      num_smul [AXES];
	logic [ROOT_BITS-1:0]     len_smul;

	logic [QUO_BITS-1:0]      quo [AXES];
	logic                     dv_vld_s  [QUO_BITS];
	front_t                   dv_info_s [QUO_BITS];

	coord_t                   res_c [AXES];
	logic                     vld_sout;
	result_t                  res_sout;

	assign en           = !vld_sout || result.ready;
	assign query.ready  = en;
	assign result.valid = vld_sout;
	assign result.data  = res_sout;

	scr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (query.valid),
		.in_data      (query.data),
		.out_valid    (f_vld),
		.out_info     (f_info),
		.out_radicand (f_rad)
	);

	scr_sqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (f_rad),
		.root     (root)
	);

	genvar g;
	generate
		for (g = 0; g < AXES; g++) begin : g_div
			scr_div u_div (
				.clk       (clk),
				.en        (en),
				.numerator (num_smul[g]),
				.divisor   (len_smul),
				.quotient  (quo[g])
			);
		end
	endgenerate

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			if (dv_info_s[QUO_BITS-1].push) begin
				if (dv_info_s[QUO_BITS-1].neg[i]) begin
					res_c[i] = sat_coord(EXT_BITS'($signed(dv_info_s[QUO_BITS-1].obst[i]))
						- EXT_BITS'(quo[i]));
				end else begin
					res_c[i] = sat_coord(EXT_BITS'($signed(dv_info_s[QUO_BITS-1].obst[i]))
						+ EXT_BITS'(quo[i]));
				end
			end else begin
				res_c[i] = dv_info_s[QUO_BITS-1].base[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ROOT_BITS; k++) begin
				sq_vld_s[k] <= 1'b0;
			end
			vld_smul <= 1'b0;
			for (int k = 0; k < QUO_BITS; k++) begin
				dv_vld_s[k] <= 1'b0;
			end
			vld_sout <= 1'b0;
		end else if (en) begin
			sq_vld_s[0] <= f_vld;
			for (int k = 1; k < ROOT_BITS; k++) begin
				sq_vld_s[k] <= sq_vld_s[k-1];
			end
			vld_smul <= sq_vld_s[ROOT_BITS-1];
			dv_vld_s[0] <= vld_smul;
			for (int k = 1; k < QUO_BITS; k++) begin
				dv_vld_s[k] <= dv_vld_s[k-1];
			end
			vld_sout <= dv_vld_s[QUO_BITS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_info_s[0] <= f_info;
			for (int k = 1; k < ROOT_BITS; k++) begin
				sq_info_s[k] <= sq_info_s[k-1];
			end
			// |e_i| * (sum of radii), below 2^64 whenever a push is needed
			info_smul <= sq_info_s[ROOT_BITS-1];
			len_smul  <= root;
			for (int i = 0; i < AXES; i++) begin
				num_smul[i] <= NUM_BITS'(sq_info_s[ROOT_BITS-1].mag[i])
					* NUM_BITS'(sq_info_s[ROOT_BITS-1].sum);
			end
			dv_info_s[0] <= info_smul;
			for (int k = 1; k < QUO_BITS; k++) begin
				dv_info_s[k] <= dv_info_s[k-1];
			end
			res_sout.result_x <= res_c[0];
			res_sout.result_y <= res_c[1];
			res_sout.result_z <= res_c[2];
		end
	end

endmodule
`default_nettype wire

FILE: src/scr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scr_front
// Four stage front end: offsets, magnitudes, cross products and squares,
// box face selection and sphere overlap test.
// ----------------------------------------------------------------------------
module scr_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  scr_pkg::query_t                     in_data,
	output logic                                out_valid,
	output scr_pkg::front_t                     out_info,
	output logic [scr_pkg::RADICAND_BITS-1:0]   out_radicand
);
	import scr_pkg::*;

	// stage 1
	coord_t                     p_c [AXES];
	coord_t                     o_c [AXES];
	rad_t                       sz_c [AXES];
	logic signed [OFS_BITS-1:0] d_c [AXES];
	logic signed [MAG_BITS-1:0] e_c [AXES];
	logic [SUM_BITS-1:0]        sum_c;

	logic                       vld_s1;
	opcode_t                    op_s1;
	coord_t                     p_s1 [AXES];
	coord_t                     o_s1 [AXES];
	rad_t                       sz_s1 [AXES];
	rad_t                       pr_s1;
	logic signed [OFS_BITS-1:0] d_s1 [AXES];
	logic signed [MAG_BITS-1:0] e_s1 [AXES];
	logic [SUM_BITS-1:0]        sum_s1;

	// stage 2
	logic [MAG_BITS-1:0]        a_c [AXES];
	logic [MAG_BITS-1:0]        ae_c [AXES];
	logic [AXES-1:0]            dpos_c;
	logic [AXES-1:0]            eneg_c;
	logic                       far_c;

	logic                       vld_s2;
	opcode_t                    op_s2;
	coord_t                     p_s2 [AXES];
	coord_t                     o_s2 [AXES];
	rad_t                       sz_s2 [AXES];
	rad_t                       pr_s2;
	logic [MAG_BITS-1:0]        a_s2 [AXES];
	logic [MAG_BITS-1:0]        ae_s2 [AXES];
	logic [AXES-1:0]            dpos_s2;
	logic [AXES-1:0]            eneg_s2;
	logic                       far_s2;
	logic [SUM_BITS-1:0]        sum_s2;

	// stage 3
	logic [PROD_BITS-1:0]       xp_c [6];
	logic [SQ_BITS-1:0]         sq_c [AXES];
	logic signed [EXT_BITS-1:0] hi_c [AXES];
	logic signed [EXT_BITS-1:0] lo_c [AXES];
	logic [RADICAND_BITS-1:0]   sum2_c;

	logic                       vld_s3;
	opcode_t                    op_s3;
	coord_t                     p_s3 [AXES];
	coord_t                     o_s3 [AXES];
	logic [PROD_BITS-1:0]       xp_s3 [6];
	logic [SQ_BITS-1:0]         sq_s3 [AXES];
	logic signed [EXT_BITS-1:0] hi_s3 [AXES];
	logic signed [EXT_BITS-1:0] lo_s3 [AXES];
	logic [RADICAND_BITS-1:0]   sum2_s3;
	logic [MAG_BITS-1:0]        ae_s3 [AXES];
	logic [AXES-1:0]            dpos_s3;
	logic [AXES-1:0]            eneg_s3;
	logic                       far_s3;
	logic [SUM_BITS-1:0]        sum_s3;

	// stage 4
	logic                       x_win;
	logic                       y_win;
	logic [AXES-1:0]            sel_c;
	logic [DIST_BITS-1:0]       d2_c;
	logic                       overlap_c;
	front_t                     info_c;

	logic                       vld_s4;
	front_t                     info_s4;
	logic [RADICAND_BITS-1:0]   rad_s4;

	always_comb begin
		p_c[0]  = in_data.player_x;
		p_c[1]  = in_data.player_y;
		p_c[2]  = in_data.player_z;
		o_c[0]  = in_data.obstacle_x;
		o_c[1]  = in_data.obstacle_y;
		o_c[2]  = in_data.obstacle_z;
		sz_c[0] = in_data.box_size_x;
		sz_c[1] = in_data.box_size_y;
		sz_c[2] = in_data.box_size_z;
		for (int i = 0; i < AXES; i++) begin
			// zero size counts as one lsb
			if (sz_c[i] == '0) begin
				sz_c[i] = RAD_BITS'(1);
			end
			d_c[i] = OFS_BITS'(p_c[i]) - (OFS_BITS'(o_c[i]) + OFS_BITS'(sz_c[i] >> 1));
			e_c[i] = MAG_BITS'(p_c[i]) - MAG_BITS'(o_c[i]);
		end
		sum_c = SUM_BITS'(in_data.player_radius) + SUM_BITS'(in_data.obstacle_radius);
	end

	always_comb begin
		far_c = 1'b1;
		for (int i = 0; i < AXES; i++) begin
			a_c[i]    = d_s1[i][OFS_BITS-1] ? MAG_BITS'(-d_s1[i]) : MAG_BITS'(d_s1[i]);
			dpos_c[i] = !d_s1[i][OFS_BITS-1] && (d_s1[i] != '0);
			far_c     = far_c && (a_c[i] > MAG_BITS'(pr_s1));
			ae_c[i]   = e_s1[i][MAG_BITS-1] ? MAG_BITS'(-e_s1[i]) : MAG_BITS'(e_s1[i]);
			eneg_c[i] = e_s1[i][MAG_BITS-1];
		end
	end

	always_comb begin
		// |a_i| / s_i compared by cross multiplication
		xp_c[0] = PROD_BITS'(a_s2[0]) * PROD_BITS'(sz_s2[1]);
		xp_c[1] = PROD_BITS'(a_s2[1]) * PROD_BITS'(sz_s2[0]);
		xp_c[2] = PROD_BITS'(a_s2[0]) * PROD_BITS'(sz_s2[2]);
		xp_c[3] = PROD_BITS'(a_s2[2]) * PROD_BITS'(sz_s2[0]);
		xp_c[4] = PROD_BITS'(a_s2[1]) * PROD_BITS'(sz_s2[2]);
		xp_c[5] = PROD_BITS'(a_s2[2]) * PROD_BITS'(sz_s2[1]);
		for (int i = 0; i < AXES; i++) begin
			sq_c[i] = SQ_BITS'(ae_s2[i]) * SQ_BITS'(ae_s2[i]);
			hi_c[i] = EXT_BITS'(o_s2[i]) + EXT_BITS'(sz_s2[i]) + EXT_BITS'(pr_s2);
			lo_c[i] = EXT_BITS'(o_s2[i]) - EXT_BITS'(pr_s2);
		end
		sum2_c = RADICAND_BITS'(sum_s2) * RADICAND_BITS'(sum_s2);
	end

	always_comb begin
		x_win     = (xp_s3[0] > xp_s3[1]) && (xp_s3[2] > xp_s3[3]);
		y_win     = xp_s3[4] > xp_s3[5];
		sel_c     = x_win ? 3'b001 : (y_win ? 3'b010 : 3'b100);
		d2_c      = DIST_BITS'(sq_s3[0]) + DIST_BITS'(sq_s3[1]) + DIST_BITS'(sq_s3[2]);
		overlap_c = d2_c < DIST_BITS'(sum2_s3);
		info_c.push = (op_s3 == OP_SPHERE) && overlap_c && (d2_c != '0);
		info_c.sum  = sum_s3;
		for (int i = 0; i < AXES; i++) begin
			info_c.base[i] = p_s3[i];
			if (op_s3 == OP_BOX) begin
				if (!far_s3 && sel_c[i]) begin
					info_c.base[i] = dpos_s3[i] ? sat_coord(hi_s3[i]) : sat_coord(lo_s3[i]);
				end
			end else if (overlap_c) begin
				info_c.base[i] = o_s3[i];
			end
			info_c.obst[i] = o_s3[i];
			info_c.mag[i]  = ae_s3[i];
			info_c.neg[i]  = eneg_s3[i];
		end
		// coincident centres push along +x
		if (op_s3 == OP_SPHERE && overlap_c) begin
			info_c.base[0] = sat_coord(EXT_BITS'(o_s3[0]) + EXT_BITS'(sum_s3));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= in_data.opcode;
			p_s1    <= p_c;
			o_s1    <= o_c;
			sz_s1   <= sz_c;
			pr_s1   <= in_data.player_radius;
			d_s1    <= d_c;
			e_s1    <= e_c;
			sum_s1  <= sum_c;

			op_s2   <= op_s1;
			p_s2    <= p_s1;
			o_s2    <= o_s1;
			sz_s2   <= sz_s1;
			pr_s2   <= pr_s1;
			a_s2    <= a_c;
			ae_s2   <= ae_c;
			dpos_s2 <= dpos_c;
			eneg_s2 <= eneg_c;
			far_s2  <= far_c;
			sum_s2  <= sum_s1;

			op_s3   <= op_s2;
			p_s3    <= p_s2;
			o_s3    <= o_s2;
			xp_s3   <= xp_c;
			sq_s3   <= sq_c;
			hi_s3   <= hi_c;
			lo_s3   <= lo_c;
			sum2_s3 <= sum2_c;
			ae_s3   <= ae_s2;
			dpos_s3 <= dpos_s2;
			eneg_s3 <= eneg_s2;
			far_s3  <= far_s2;
			sum_s3  <= sum_s2;

			info_s4 <= info_c;
			rad_s4  <= d2_c[RADICAND_BITS-1:0];
		end
	end

	assign out_valid    = vld_s4;
	assign out_info     = info_s4;
	assign out_radicand = rad_s4;

endmodule
`default_nettype wire

FILE: src/scr_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scr_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module scr_sqrt (
	input  logic                                clk,
	input  logic                                en,
	input  logic [scr_pkg::RADICAND_BITS-1:0]   radicand,
	output logic [scr_pkg::ROOT_BITS-1:0]       root
);
	import scr_pkg::*;

	logic [ROOT_REM_BITS-1:0] rem_s  [ROOT_BITS];
	logic [ROOT_BITS-1:0]     root_s [ROOT_BITS];
	logic [RADICAND_BITS-1:0] rad_s  [ROOT_BITS];

	genvar k;
	generate
		for (k = 0; k < ROOT_BITS; k++) begin : g_stage
			logic [ROOT_REM_BITS-1:0] rem_in;
			logic [ROOT_REM_BITS-1:0] trial_rem;
			logic [ROOT_REM_BITS-1:0] trial;
			logic [ROOT_REM_BITS-1:0] rem_nx;
			logic [ROOT_BITS-1:0]     root_in;
			logic [ROOT_BITS-1:0]     root_nx;
			logic [RADICAND_BITS-1:0] rad_in;

			if (k == 0) begin : g_first
				assign rem_in  = '0;
				assign root_in = '0;
				assign rad_in  = radicand;
			end else begin : g_next
				assign rem_in  = rem_s[k-1];
				assign root_in = root_s[k-1];
				assign rad_in  = rad_s[k-1];
			end

			always_comb begin
				// bring down the next two radicand bits, try (4*root + 1)
				trial_rem = {rem_in[ROOT_REM_BITS-3:0], rad_in[RADICAND_BITS-1 -: 2]};
				trial     = ROOT_REM_BITS'({root_in, 2'b01});
				if (trial_rem >= trial) begin
					rem_nx  = trial_rem - trial;
					root_nx = {root_in[ROOT_BITS-2:0], 1'b1};
				end else begin
					rem_nx  = trial_rem;
					root_nx = {root_in[ROOT_BITS-2:0], 1'b0};
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k]  <= rem_nx;
					root_s[k] <= root_nx;
					rad_s[k]  <= {rad_in[RADICAND_BITS-3:0], 2'b00};
				end
			end
		end
	endgenerate

	assign root = root_s[ROOT_BITS-1];

endmodule
`default_nettype wire

FILE: src/scr_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scr_div
// Pipelined restoring divider, one quotient bit per stage. The upper half
// of the numerator must be below the divisor.
// ----------------------------------------------------------------------------
module scr_div (
	input  logic                            clk,
	input  logic                            en,
	input  logic [scr_pkg::NUM_BITS-1:0]    numerator,
	input  logic [scr_pkg::ROOT_BITS-1:0]   divisor,
	output logic [scr_pkg::QUO_BITS-1:0]    quotient
);
	import scr_pkg::*;

	logic [DIV_REM_BITS-1:0] rem_s [QUO_BITS];
	logic [QUO_BITS-1:0]     quo_s [QUO_BITS];
	logic [QUO_BITS-1:0]     lo_s  [QUO_BITS];
	logic [ROOT_BITS-1:0]    div_s [QUO_BITS];

	genvar k;
	generate
		for (k = 0; k < QUO_BITS; k++) begin : g_stage
			logic [DIV_REM_BITS-1:0] rem_in;
			logic [DIV_REM_BITS-1:0] trial;
			logic [DIV_REM_BITS-1:0] rem_nx;
			logic [QUO_BITS-1:0]     quo_in;
			logic [QUO_BITS-1:0]     quo_nx;
			logic [QUO_BITS-1:0]     lo_in;
			logic [ROOT_BITS-1:0]    div_in;

			if (k == 0) begin : g_first
				assign rem_in = DIV_REM_BITS'(numerator[NUM_BITS-1 -: QUO_BITS]);
				assign quo_in = '0;
				assign lo_in  = numerator[QUO_BITS-1:0];
				assign div_in = divisor;
			end else begin : g_next
				assign rem_in = rem_s[k-1];
				assign quo_in = quo_s[k-1];
				assign lo_in  = lo_s[k-1];
				assign div_in = div_s[k-1];
			end

			always_comb begin
				trial = {rem_in[DIV_REM_BITS-2:0], lo_in[QUO_BITS-1]};
				if (trial >= DIV_REM_BITS'(div_in)) begin
					rem_nx = trial - DIV_REM_BITS'(div_in);
					quo_nx = {quo_in[QUO_BITS-2:0], 1'b1};
				end else begin
					rem_nx = trial;
					quo_nx = {quo_in[QUO_BITS-2:0], 1'b0};
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= rem_nx;
					quo_s[k] <= quo_nx;
					lo_s[k]  <= {lo_in[QUO_BITS-2:0], 1'b0};
					div_s[k] <= div_in;
				end
			end
		end
	endgenerate

	assign quotient = quo_s[QUO_BITS-1];

endmodule
`default_nettype wire
